[hw/rtl/bfm_pkg.sv]
package bfm_pkg;

  localparam int SymbolsPerFrameDef   = 8;
  localparam int DataBitsPerSymbolDef = 9;

  localparam int SampleW = 15;
  localparam int WaveW   = 13;
  localparam int MagW    = WaveW + 1;

  localparam logic [2:0] RegAntiVadAddr = 3'h0;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EMIT  = 1'b1
  } op_e;

  typedef struct packed {
    logic sent;
    logic dbl_first;
    logic dbl;
    logic fall_first;
    logic rise_last;
  } slot_desc_t;

  function automatic logic [WaveW-1:0] plain_wave(input logic [1:0] tap);
    logic [WaveW-1:0] v;
    case (tap)
      2'd0:    v = WaveW'(4000);
      2'd1:    v = WaveW'(8000);
      2'd2:    v = WaveW'(4000);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [WaveW-1:0] rise_wave(input logic [1:0] tap);
    logic [WaveW-1:0] v;
    case (tap)
      2'd0:    v = WaveW'(2071);
      2'd1:    v = WaveW'(5657);
      2'd2:    v = WaveW'(7727);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [WaveW-1:0] fall_wave(input logic [1:0] tap);
    logic [WaveW-1:0] v;
    case (tap)
      2'd0:    v = WaveW'(7727);
      2'd1:    v = WaveW'(5657);
      2'd2:    v = WaveW'(2071);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/bfm_slot.sv]
module bfm_slot import bfm_pkg::*; #(
  parameter int SymbolsPerFrame   = SymbolsPerFrameDef,
  parameter int DataBitsPerSymbol = DataBitsPerSymbolDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  op_e        op_i,
  input  logic [3:0] byte_index_i,
  input  logic [7:0] byte_value_i,
  input  logic       anti_vad_en_i,
  output slot_desc_t desc_o
);

  localparam int FrameBits  = SymbolsPerFrame * DataBitsPerSymbol;
  localparam int FrameBytes = (FrameBits + 7) / 8;
  localparam int SymW       = $clog2(SymbolsPerFrame);
  localparam int PosW       = $clog2(DataBitsPerSymbol + 1);
  localparam int BnW        = $clog2(FrameBytes * 8);

  logic [FrameBytes*8-1:0]   frame_q;
  logic [SymW-1:0]           sym_q, sym_d;
  logic [PosW-1:0]           pos_q, pos_d;
  logic [SymbolsPerFrame-1:0] parity_q, parity_d;
  logic held_q, held_d;
  logic ptrans_q, ptrans_d;
  logic odd_q, odd_d;
  logic lodd_q, lodd_d;
  logic llodd_q, llodd_d;

  logic             data_slot;
  logic [BnW-1:0]   bn;
  logic [SymW-1:0]  par_idx;
  logic             cur;
  logic             trans;
  logic             emit;

  assign emit      = fire_i && (op_i == OP_EMIT);
  assign data_slot = (32'(pos_q) < DataBitsPerSymbol);
  assign bn        = BnW'(32'(sym_q) * DataBitsPerSymbol + 32'(pos_q));
  assign par_idx   = SymW'(SymbolsPerFrame - 1) - sym_q;
  assign cur       = data_slot ? frame_q[bn] : parity_q[par_idx];
  assign trans     = held_q ^ cur;

  always_comb begin
    desc_o.sent       = held_q;
    desc_o.dbl_first  = anti_vad_en_i & llodd_q;
    desc_o.dbl        = anti_vad_en_i & lodd_q;
    desc_o.fall_first = ~ptrans_q;
    desc_o.rise_last  = ~trans;
  end

  // frame buffer, no reset
  always_ff @(posedge clk_i) begin
    if (fire_i && (op_i == OP_WRITE)) begin
      for (int b = 0; b < FrameBytes; b++) begin
        if (32'(byte_index_i) == b) begin
          frame_q[b*8 +: 8] <= byte_value_i;
        end
      end
    end
  end

  always_comb begin
    sym_d    = sym_q;
    pos_d    = pos_q;
    parity_d = parity_q;
    held_d   = held_q;
    ptrans_d = ptrans_q;
    odd_d    = odd_q;
    lodd_d   = lodd_q;
    llodd_d  = llodd_q;
    if (emit) begin
      if (data_slot) begin
        parity_d[sym_q] = parity_q[sym_q] ^ cur;
      end
      held_d   = cur;
      ptrans_d = trans;
      llodd_d  = lodd_q;
      lodd_d   = odd_q;
      if (sym_q == SymW'(SymbolsPerFrame - 1)) begin
        sym_d = '0;
        if (32'(pos_q) == DataBitsPerSymbol) begin
          pos_d    = '0;
          parity_d = '0;
          odd_d    = ~odd_q;
        end else begin
          pos_d = pos_q + PosW'(1);
        end
      end else begin
        sym_d = sym_q + SymW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q    <= '0;
      pos_q    <= '0;
      parity_q <= '0;
      held_q   <= 1'b1;
      ptrans_q <= 1'b1;
      odd_q    <= 1'b0;
      lodd_q   <= 1'b1;
      llodd_q  <= 1'b1;
    end else begin
      sym_q    <= sym_d;
      pos_q    <= pos_d;
      parity_q <= parity_d;
      held_q   <= held_d;
      ptrans_q <= ptrans_d;
      odd_q    <= odd_d;
      lodd_q   <= lodd_d;
      llodd_q  <= llodd_d;
    end
  end

endmodule

[hw/rtl/bfm_wave.sv]
module bfm_wave import bfm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  slot_desc_t         desc_i,
  output logic               free_o,
  output logic               tvalid_o,
  input  logic               tready_i,
  output logic [SampleW-1:0] sample_o,
  output logic               last_o
);

  logic       vld_q, vld_d;
  logic [1:0] grp_q, grp_d;
  logic [1:0] tap_q, tap_d;
  slot_desc_t desc_q;

  logic             last_tap;
  logic             take;
  logic [WaveW-1:0] wave;
  logic             dbl;
  logic             neg;
  logic [MagW-1:0]  mag;

  assign last_tap = (grp_q == 2'd2) && (tap_q == 2'd2);
  assign take     = vld_q && tready_i;
  assign free_o   = !vld_q || (tready_i && last_tap);
  assign tvalid_o = vld_q;
  assign last_o   = last_tap;

  always_comb begin
    case (grp_q)
      2'd0: begin
        wave = desc_q.fall_first ? fall_wave(tap_q) : plain_wave(tap_q);
        dbl  = desc_q.dbl_first;
        neg  = desc_q.sent;
      end
      2'd1: begin
        wave = plain_wave(tap_q);
        dbl  = desc_q.dbl;
        neg  = ~desc_q.sent;
      end
      2'd2: begin
        wave = desc_q.rise_last ? rise_wave(tap_q) : plain_wave(tap_q);
        dbl  = desc_q.dbl;
        neg  = desc_q.sent;
      end
      default: begin
        wave = '0;
        dbl  = 1'b0;
        neg  = 1'b0;
      end
    endcase
    mag      = dbl ? {wave, 1'b0} : {1'b0, wave};
    sample_o = neg ? (SampleW'(0) - {1'b0, mag}) : {1'b0, mag};
  end

  always_comb begin
    vld_d = vld_q;
    grp_d = grp_q;
    tap_d = tap_q;
    if (take) begin
      if (last_tap) begin
        vld_d = 1'b0;
      end else if (tap_q == 2'd2) begin
        tap_d = 2'd0;
        grp_d = grp_q + 2'd1;
      end else begin
        tap_d = tap_q + 2'd1;
      end
    end
    if (load_i) begin
      vld_d = 1'b1;
      grp_d = 2'd0;
      tap_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      grp_q <= 2'd0;
      tap_q <= 2'd0;
    end else begin
      vld_q <= vld_d;
      grp_q <= grp_d;
      tap_q <= tap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      desc_q <= desc_i;
    end
  end

endmodule

[hw/rtl/bpsk_frame_modulator_core.sv]
// BPSK frame modulator. Write transactions (tuser = 0) load frame bytes without waiting
// on the output; emit transactions (tuser = 1) send the next interleaved bit slot of the
// frame, data slots first and per-symbol parity last, as nine PCM samples on the master
// stream with tlast on the ninth. The output sequencer gives one sample per cycle while
// the master stream is ready, and holds one slot while the next transaction
// waits in the input register. Each slot sends the bit held from the slot before, so
// samples trail the frame by one slot. Frame bytes are not reset and must be written
// before they are sent; anti_vad_enable (address 0x0) doubles the amplitude of bits
// from odd frames.
module bpsk_frame_modulator_core import bfm_pkg::*; #(
  parameter int SymbolsPerFrame   = SymbolsPerFrameDef,
  parameter int DataBitsPerSymbol = DataBitsPerSymbolDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // byte_index [3:0], byte_value [11:4]
  input  logic        s_axis_tuser_i,   // op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // sample [14:0]
  output logic        m_axis_tlast_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  logic       in_vld_q;
  op_e        in_op_q;
  logic [3:0] in_idx_q;
  logic [7:0] in_val_q;
  logic       anti_vad_q;

  logic               fire;
  logic               wave_free;
  slot_desc_t         desc;
  logic [SampleW-1:0] sample;

  assign fire            = in_vld_q && ((in_op_q == OP_WRITE) || wave_free);
  assign s_axis_tready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_op_q  <= op_e'(s_axis_tuser_i);
      in_idx_q <= s_axis_tdata_i[3:0];
      in_val_q <= s_axis_tdata_i[11:4];
    end
  end

  // config register
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i == RegAntiVadAddr) ? {31'b0, anti_vad_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anti_vad_q <= 1'b0;
    end else if (psel_i && penable_i && pwrite_i && pready_o
                 && (paddr_i == RegAntiVadAddr)) begin
      anti_vad_q <= pwdata_i[0];
    end
  end

  bfm_slot #(
    .SymbolsPerFrame  (SymbolsPerFrame),
    .DataBitsPerSymbol(DataBitsPerSymbol)
  ) u_slot (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .op_i         (in_op_q),
    .byte_index_i (in_idx_q),
    .byte_value_i (in_val_q),
    .anti_vad_en_i(anti_vad_q),
    .desc_o       (desc)
  );

  bfm_wave u_wave (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && (in_op_q == OP_EMIT)),
    .desc_i  (desc),
    .free_o  (wave_free),
    .tvalid_o(m_axis_tvalid_o),
    .tready_i(m_axis_tready_i),
    .sample_o(sample),
    .last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, sample};

endmodule

[tb/sv/tb.sv]
module tb;
  import bfm_pkg::*;

  localparam int Syms   = SymbolsPerFrameDef;
  localparam int Bits   = DataBitsPerSymbolDef;
  localparam int Slots  = Syms * (Bits + 1);
  localparam int NBytes = (Syms * Bits + 7) / 8;

  typedef struct {
    op_e        op;
    logic [3:0] idx;
    logic [7:0] val;
  } mod_item_t;

  typedef struct {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } pcm_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  always #5 clk_i = ~clk_i;

  bpsk_frame_modulator_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tlast_o (m_tlast),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_o       (prdata),
    .pready_o       (pready)
  );

  // modulator state as predicted
  logic [7:0] frame_mem [NBytes];
  logic       par [Syms];
  int         slot_cnt = 0;
  logic       held = 1'b1;
  logic       prev_trans = 1'b1;
  logic       frame_odd = 1'b0;
  logic       lfo = 1'b1;
  logic       llfo = 1'b1;
  logic       anti_vad = 1'b0;

  int plain_w [3] = '{4000, 8000, 4000};
  int rise_w  [3] = '{2071, 5657, 7727};
  int fall_w  [3] = '{7727, 5657, 2071};

  mod_item_t stim_q [$];
  pcm_t      pcm_q [$];
  mod_item_t cur_item;
  pcm_t      want;

  int   errors = 0;
  int   n_emit = 0;
  int   n_write = 0;
  int   n_samples = 0;
  int   frames_done = 0;
  int   src_gap = 0;
  int   snk_stall = 0;
  logic src_quiet = 1'b0;
  logic snk_quiet = 1'b0;

  function automatic int gap_len(input logic quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic void push_pcm(input int v, input logic last);
    pcm_t p;
    p.sample = SampleW'(v);
    p.last   = last;
    pcm_q.push_back(p);
  endfunction

  function automatic void modulate_item(input mod_item_t it);
    int   sym;
    int   pos;
    int   bn;
    int   amp;
    int   amp1;
    logic cur;
    logic sent;
    logic trans;
    if (it.op == OP_WRITE) begin
      n_write++;
      if (it.idx < NBytes) frame_mem[it.idx] = it.val;
      return;
    end
    n_emit++;
    sym = slot_cnt % Syms;
    pos = slot_cnt / Syms;
    if (pos < Bits) begin
      bn = sym * Bits + pos;
      cur = frame_mem[bn / 8][bn % 8];
      par[sym] = par[sym] ^ cur;
    end else begin
      cur = par[Syms - 1 - sym];
    end
    sent  = held;
    held  = cur;
    trans = sent ^ cur;
    amp   = sent ? -1 : 1;
    amp1  = amp;
    if (anti_vad) begin
      amp  = amp * (lfo ? 2 : 1);
      amp1 = amp1 * (llfo ? 2 : 1);
    end
    for (int n = 0; n < 3; n++) push_pcm(amp1 * (prev_trans ? plain_w[n] : fall_w[n]), 1'b0);
    for (int n = 0; n < 3; n++) push_pcm(-amp * plain_w[n], 1'b0);
    for (int n = 0; n < 3; n++) push_pcm(amp * (trans ? plain_w[n] : rise_w[n]), n == 2);
    prev_trans = trans;
    llfo = lfo;
    lfo  = frame_odd;
    slot_cnt++;
    if (slot_cnt >= Slots) begin
      slot_cnt = 0;
      for (int s = 0; s < Syms; s++) par[s] = 1'b0;
      frame_odd = ~frame_odd;
      frames_done++;
    end
  endfunction

  initial begin
    for (int s = 0; s < Syms; s++) par[s] = 1'b0;
  end

  // source side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) modulate_item(cur_item);
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (stim_q.size() > 0) begin
          cur_item = stim_q.pop_front();
          s_tdata  <= {4'h0, cur_item.val, cur_item.idx};
          s_tuser  <= cur_item.op;
          s_tvalid <= 1'b1;
          if ($urandom_range(0, 39) == 0) src_quiet = ~src_quiet;
          src_gap = gap_len(src_quiet);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_samples++;
        if (pcm_q.size() == 0) begin
          $error("sample: no transaction expected, actual %0d",
                 $signed(m_tdata[SampleW-1:0]));
          errors++;
        end else begin
          want = pcm_q.pop_front();
          if (m_tdata[SampleW-1:0] !== want.sample) begin
            $error("sample: expected %0d, actual %0d", want.sample,
                   $signed(m_tdata[SampleW-1:0]));
            errors++;
          end
          if (m_tlast !== want.last) begin
            $error("last_sample: expected %0b, actual %0b", want.last, m_tlast);
            errors++;
          end
        end
      end
      if (snk_stall > 0) begin
        snk_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 49) == 0) snk_quiet = ~snk_quiet;
        if ($urandom_range(0, 3) == 0) snk_stall = gap_len(snk_quiet);
      end
    end
  end

  function automatic void push_write(input logic [3:0] idx, input logic [7:0] val);
    mod_item_t it;
    it.op  = OP_WRITE;
    it.idx = idx;
    it.val = val;
    stim_q.push_back(it);
  endfunction

  function automatic void push_emit();
    mod_item_t it;
    it.op  = OP_EMIT;
    it.idx = 4'($urandom_range(0, 15));
    it.val = 8'($urandom_range(0, 255));
    stim_q.push_back(it);
  endfunction

  task automatic run_random(input int count, input int emit_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < emit_pct) begin
        push_emit();
      end else if ($urandom_range(0, 4) == 0) begin
        push_write(4'($urandom_range(NBytes, 15)), 8'($urandom_range(0, 255)));
      end else begin
        push_write(4'($urandom_range(0, NBytes - 1)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (stim_q.size() != 0 || s_tvalid || pcm_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_anti_vad(input logic v);
    logic [31:0] rd;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegAntiVadAddr;
    pwdata  <= {31'b0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel     <= 1'b0;
    penable  <= 1'b0;
    anti_vad = v;
    @(posedge clk_i);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rd = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[0] !== v) begin
      $error("anti_vad_enable: expected %0b, actual %0b", v, rd[0]);
      errors++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // whole frame loaded before the first slot
    push_write(4'd0, 8'h00);
    push_write(4'd1, 8'hFF);
    push_write(4'd2, 8'hA5);
    push_write(4'd3, 8'h5A);
    push_write(4'd4, 8'h01);
    push_write(4'd5, 8'h80);
    push_write(4'd6, 8'hFF);
    push_write(4'd7, 8'h00);
    push_write(4'd8, 8'hC3);
    // out of range, ignored
    push_write(4'd9, 8'h00);
    push_write(4'd15, 8'hFF);
    repeat (8) push_emit();
    // rewrite during a frame
    push_write(4'd0, 8'h3C);
    repeat (4) push_emit();
    wait_idle();

    set_anti_vad(1'b1);
    run_random(110, 85);
    wait_idle();

    set_anti_vad(1'b0);
    run_random(90, 70);
    wait_idle();

    set_anti_vad(1'b1);
    run_random(90, 80);
    wait_idle();

    $display("%0d emit and %0d write transactions, %0d samples checked", n_emit, n_write,
             n_samples);
    $display("%0d frames completed, anti-VAD toggled on and off", frames_done);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
